/* sv/iso14443a_anticollision_initiator_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef ISO14443A_ANTICOLLISION_INITIATOR_UNIT_DEFINES_SVH
`define ISO14443A_ANTICOLLISION_INITIATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define I14A_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i14a_aci: same-cycle rule violated");

// Next-cycle implication, disabled while reset is low.
`define I14A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i14a_aci: next-cycle rule violated");

`endif

/* sv/i14a_aci_pkg.sv */
`timescale 1ns / 1ps
package i14a_aci_pkg;

    localparam int UID_BYTES = 10;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_FRAME = 2'd1;
    localparam logic [1:0] CMD_FAIL  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PROTO = 2'd1;
    localparam logic [1:0] ST_LINK  = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic [7:0] WUPA_CODE   = 8'h52;
    localparam logic [7:0] NVB_ANTI    = 8'h02 << 4;
    localparam logic [7:0] NVB_SEL     = 8'h07 << 4;
    localparam logic [7:0] CASCADE_TAG = 8'h88;
    localparam logic [4:0] ATQA_MASK   = 5'h1f;
    localparam logic [7:0] SAK_CASCADE = 8'h04;
    localparam int         SAK_CASCADE_BIT = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ATQA,
        PH_ANTI,
        PH_SAK
    } t_phase;

    typedef enum logic [1:0] {
        OP_START,
        OP_FRAME,
        OP_FAIL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        len1;
        logic        len2;
        logic        len5;
        logic        bcc_ok;
        logic        tag;
        logic        atqa_any;
        logic [39:0] rx_data;
        logic [7:0]  link_error;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [55:0] tx_data;
        logic [2:0]  tx_length;
        logic [2:0]  tx_last_bits;
        logic        tx_crc;
        logic [1:0]  status;
        logic [7:0]  link_code;
        logic [15:0] atqa;
        logic [7:0]  sak;
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [3:0]  uid_length;
    } t_result;

    function automatic logic [7:0] sel_code(input logic [1:0] lvl);
        logic [7:0] code;
        unique case (lvl)
            2'd0:    code = 8'h93;
            2'd1:    code = 8'h95;
            default: code = 8'h97;
        endcase
        return code;
    endfunction

endpackage

/* sv/i14a_aci_in_if.sv */
`timescale 1ns / 1ps
interface i14a_aci_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  rx_length;
    logic [39:0] rx_data;
    logic [7:0]  link_error;

    modport source (output valid, command, rx_length, rx_data, link_error, input ready);
    modport sink   (input valid, command, rx_length, rx_data, link_error, output ready);
endinterface

/* sv/i14a_aci_out_if.sv */
`timescale 1ns / 1ps
interface i14a_aci_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [55:0] tx_data;
    logic [2:0]  tx_length;
    logic [2:0]  tx_last_bits;
    logic        tx_crc;
    logic [1:0]  status;
    logic [7:0]  link_code;
    logic [15:0] atqa;
    logic [7:0]  sak;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
    logic [3:0]  uid_length;

    modport source (
        output valid, kind, tx_data, tx_length, tx_last_bits, tx_crc, status,
               link_code, atqa, sak, uid_low, uid_high, uid_length,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_data, tx_length, tx_last_bits, tx_crc, status,
               link_code, atqa, sak, uid_low, uid_high, uid_length,
        output ready
    );
endinterface

/* sv/i14a_aci_front.sv */
`timescale 1ns / 1ps
module i14a_aci_front
    import i14a_aci_pkg::*;
(
    i14a_aci_in_if.sink i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic [7:0] bcc;

    always_comb begin
        bcc = i_in.rx_data[7:0] ^ i_in.rx_data[15:8] ^ i_in.rx_data[23:16]
            ^ i_in.rx_data[31:24];

        i_in.ready = !i_q_full;
        // unused command words are taken and dropped here
        o_push = i_in.valid && !i_q_full && (i_in.command != CMD_NONE);

        priority if (i_in.command == CMD_START) begin
            o_item.op = OP_START;
        end else if (i_in.command == CMD_FRAME) begin
            o_item.op = OP_FRAME;
        end else begin
            o_item.op = OP_FAIL;
        end
        o_item.len1       = (i_in.rx_length == 3'd1);
        o_item.len2       = (i_in.rx_length == 3'd2);
        o_item.len5       = (i_in.rx_length == 3'd5);
        o_item.bcc_ok     = (bcc == i_in.rx_data[39:32]);
        o_item.tag        = (i_in.rx_data[7:0] == CASCADE_TAG);
        o_item.atqa_any   = |(i_in.rx_data[4:0] & ATQA_MASK);
        o_item.rx_data    = i_in.rx_data;
        o_item.link_error = i_in.link_error;
    end

endmodule

/* sv/i14a_aci_queue.sv */
`timescale 1ns / 1ps
module i14a_aci_queue
    import i14a_aci_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* sv/i14a_aci_back.sv */
`timescale 1ns / 1ps
module i14a_aci_back
    import i14a_aci_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_item i_item,
    output logic  o_q_pop,
    i14a_aci_out_if.source o_out
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_level,  n_level;
    logic [7:0]  r_uid [UID_BYTES];
    logic [7:0]  n_uid [UID_BYTES];
    logic [3:0]  r_count,  n_count;
    logic [15:0] r_atqa,   n_atqa;
    logic [7:0]  r_sak,    n_sak;
    logic        r_tag,    n_tag;
    logic        r_out_valid;
    t_result     r_out,    n_out;

    logic        fin;
    logic [1:0]  fin_status;
    logic [7:0]  fin_code;
    logic        frm;
    logic [55:0] frm_data;
    logic [2:0]  frm_len;
    logic [2:0]  frm_last;
    logic        frm_crc;
    logic [3:0]  add_cnt;
    logic [4:0]  sum_cnt;
    logic [3:0]  ofs;
    logic [1:0]  bsel;
    logic [3:0][7:0] rb;
    logic [7:0]  b0;

    always_comb begin
        rb = i_item.rx_data[31:0];
        b0 = i_item.rx_data[7:0];
        o_q_pop = i_q_valid && (!r_out_valid || o_out.ready);

        n_phase = r_phase;
        n_level = r_level;
        n_uid   = r_uid;
        n_count = r_count;
        n_atqa  = r_atqa;
        n_sak   = r_sak;
        n_tag   = r_tag;

        fin        = 1'b0;
        fin_status = ST_OK;
        fin_code   = 8'd0;
        frm        = 1'b0;
        frm_data   = 56'd0;
        frm_len    = 3'd0;
        frm_last   = 3'd0;
        frm_crc    = 1'b0;
        add_cnt    = i_item.tag ? 4'd3 : 4'd4;
        sum_cnt    = {1'b0, r_count} + {1'b0, add_cnt};
        ofs        = 4'd0;
        bsel       = 2'd0;

        unique case (i_item.op)
            OP_START: begin
                for (int j = 0; j < UID_BYTES; j++) begin
                    n_uid[j] = 8'd0;
                end
                n_count  = 4'd0;
                n_level  = 2'd0;
                n_tag    = 1'b0;
                n_phase  = PH_ATQA;
                frm      = 1'b1;
                frm_data = {48'd0, WUPA_CODE};
                frm_len  = 3'd1;
                frm_last = 3'd7;
            end
            OP_FAIL: begin
                if (r_phase != PH_IDLE) begin
                    fin        = 1'b1;
                    fin_status = ST_LINK;
                    fin_code   = i_item.link_error;
                end
            end
            OP_FRAME: begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_ATQA: begin
                        if (!i_item.len2) begin
                            fin        = 1'b1;
                            fin_status = ST_PROTO;
                        end else begin
                            n_atqa = i_item.rx_data[15:0];
                            if (!i_item.atqa_any) begin
                                fin        = 1'b1;
                                fin_status = ST_PROTO;
                            end else begin
                                n_level  = 2'd0;
                                n_phase  = PH_ANTI;
                                frm      = 1'b1;
                                frm_data = {40'd0, NVB_ANTI, sel_code(2'd0)};
                                frm_len  = 3'd2;
                            end
                        end
                    end
                    PH_ANTI: begin
                        if (!i_item.len5 || !i_item.bcc_ok) begin
                            fin        = 1'b1;
                            fin_status = ST_PROTO;
                        end else begin
                            n_tag = i_item.tag;
                            for (int j = 0; j < UID_BYTES; j++) begin
                                ofs  = 4'(j) - r_count;
                                bsel = 2'({1'b0, i_item.tag} + ofs[1:0]);
                                if ((4'(j) >= r_count) && (ofs < add_cnt)) begin
                                    n_uid[j] = rb[bsel];
                                end
                            end
                            n_count  = (sum_cnt > 5'(UID_BYTES)) ? 4'(UID_BYTES)
                                                                  : sum_cnt[3:0];
                            n_phase  = PH_SAK;
                            frm      = 1'b1;
                            frm_data = {i_item.rx_data, NVB_SEL, sel_code(r_level)};
                            frm_len  = 3'd7;
                            frm_crc  = 1'b1;
                        end
                    end
                    PH_SAK: begin
                        if (!i_item.len1) begin
                            fin        = 1'b1;
                            fin_status = ST_PROTO;
                        end else begin
                            n_sak = b0;
                            if (b0[SAK_CASCADE_BIT] != r_tag) begin
                                fin        = 1'b1;
                                fin_status = ST_PROTO;
                            end else if ((b0 & SAK_CASCADE) != 8'd0) begin
                                if (r_level >= 2'd2) begin
                                    fin        = 1'b1;
                                    fin_status = ST_PROTO;
                                end else begin
                                    n_level  = r_level + 2'd1;
                                    n_phase  = PH_ANTI;
                                    frm      = 1'b1;
                                    frm_data = {40'd0, NVB_ANTI, sel_code(r_level + 2'd1)};
                                    frm_len  = 3'd2;
                                end
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_OK;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (fin) begin
            n_phase = PH_IDLE;
        end

        n_out.kind         = fin ? KIND_DONE : KIND_FRAME;
        n_out.tx_data      = frm_data;
        n_out.tx_length    = frm_len;
        n_out.tx_last_bits = frm_last;
        n_out.tx_crc       = frm_crc;
        n_out.status       = fin_status;
        n_out.link_code    = fin_code;
        n_out.atqa         = n_atqa;
        n_out.sak          = n_sak;
        n_out.uid_low      = {n_uid[7], n_uid[6], n_uid[5], n_uid[4],
                              n_uid[3], n_uid[2], n_uid[1], n_uid[0]};
        n_out.uid_high     = {n_uid[9], n_uid[8]};
        n_out.uid_length   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_level     <= 2'd0;
            r_count     <= 4'd0;
            r_atqa      <= 16'd0;
            r_sak       <= 8'd0;
            r_tag       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < UID_BYTES; j++) begin
                r_uid[j] <= 8'd0;
            end
        end else begin
            if (o_q_pop) begin
                r_phase     <= n_phase;
                r_level     <= n_level;
                r_count     <= n_count;
                r_atqa      <= n_atqa;
                r_sak       <= n_sak;
                r_tag       <= n_tag;
                r_uid       <= n_uid;
                r_out_valid <= fin || frm;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (fin || frm)) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.tx_data      = r_out.tx_data;
    assign o_out.tx_length    = r_out.tx_length;
    assign o_out.tx_last_bits = r_out.tx_last_bits;
    assign o_out.tx_crc       = r_out.tx_crc;
    assign o_out.status       = r_out.status;
    assign o_out.link_code    = r_out.link_code;
    assign o_out.atqa         = r_out.atqa;
    assign o_out.sak          = r_out.sak;
    assign o_out.uid_low      = r_out.uid_low;
    assign o_out.uid_high     = r_out.uid_high;
    assign o_out.uid_length   = r_out.uid_length;

endmodule

/* sv/iso14443a_anticollision_initiator_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Words
// i_in      in   command, rx_length, rx_data, link_error (start, reply frame, link failure)
// o_out     out  kind, tx frame fields, status, link_code, atqa, sak, uid fields
//
// One input word per cycle while o_out does not stall; a word enters a two-entry queue at acceptance.
// It leaves the queue at the next edge at the earliest, and that edge loads its result,
// if any, into the output register.
// The sequencer step for one word is computed combinationally into the state registers.
// Synchronous active-low reset clears phase, level, UID store, ATQA, SAK and the queue.
// A stalled o_out holds the output register; i_in keeps accepting until the queue fills.
module iso14443a_anticollision_initiator_unit
    import i14a_aci_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    i14a_aci_in_if.sink     i_in,
    i14a_aci_out_if.source  o_out
);

    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_item front_item;
    t_item head_item;

    i14a_aci_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    i14a_aci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (q_pop)
    );

    i14a_aci_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (head_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

/* sv/i14a_aci_chk.sv */
`timescale 1ns / 1ps
`include "iso14443a_anticollision_initiator_unit_defines.svh"
module i14a_aci_chk
    import i14a_aci_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [55:0] i_tx_data,
    input logic [2:0]  i_tx_length,
    input logic [1:0]  i_status,
    input logic [7:0]  i_link_code,
    input logic [3:0]  i_uid_length
);

    `I14A_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `I14A_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_tx_data) && $stable(i_kind) && $stable(i_uid_length))
    `I14A_ASSERT_IMPL(a_done_no_frame, i_clk, i_rst_n, i_out_valid && (i_kind == KIND_DONE), (i_tx_length == 3'd0) && (i_tx_data == 56'd0))
    `I14A_ASSERT_IMPL(a_frame_clean, i_clk, i_rst_n, i_out_valid && (i_kind == KIND_FRAME), (i_status == ST_OK) && (i_link_code == 8'd0) && (i_tx_length != 3'd0))
    `I14A_ASSERT_IMPL(a_uid_bound, i_clk, i_rst_n, i_out_valid, (i_uid_length <= 4'd10) && (i_status != 2'd3))

endmodule

bind iso14443a_anticollision_initiator_unit i14a_aci_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kind       (o_out.kind),
    .i_tx_data    (o_out.tx_data),
    .i_tx_length  (o_out.tx_length),
    .i_status     (o_out.status),
    .i_link_code  (o_out.link_code),
    .i_uid_length (o_out.uid_length)
);

/* bench/tb_iso14443a_anticollision_initiator_unit.sv */
`timescale 1ns / 1ps
module tb_iso14443a_anticollision_initiator_unit;
    import i14a_aci_pkg::*;

    class uid_sequencer_scoreboard;
        t_phase      phase;
        logic [1:0]  level;
        logic [7:0]  uid_store [UID_BYTES];
        logic [3:0]  uid_count;
        logic [15:0] atqa_q;
        logic [7:0]  sak_q;
        logic        tag_seen;
        t_result     pending [$];
        int          errors;

        function new();
            phase = PH_IDLE;
            level = 2'd0;
            foreach (uid_store[i]) uid_store[i] = 8'h00;
            uid_count = 4'd0;
            atqa_q = 16'h0000;
            sak_q = 8'h00;
            tag_seen = 1'b0;
            errors = 0;
        endfunction

        function logic [7:0] select_code();
            return (level >= 2'd2) ? 8'h97 : 8'h93 + {5'd0, level, 1'b0};
        endfunction

        function t_result current_regs();
            t_result r;
            r = '0;
            r.atqa = atqa_q;
            r.sak = sak_q;
            for (int i = 7; i >= 0; i--) r.uid_low = {r.uid_low[55:0], uid_store[i]};
            r.uid_high = {uid_store[9], uid_store[8]};
            r.uid_length = uid_count;
            return r;
        endfunction

        function void push_frame(logic [55:0] data, logic [2:0] n, logic [2:0] last,
                                 logic crc);
            t_result r;
            r = current_regs();
            r.kind = KIND_FRAME;
            r.tx_data = data;
            r.tx_length = n;
            r.tx_last_bits = last;
            r.tx_crc = crc;
            pending.push_back(r);
        endfunction

        function void push_done(logic [1:0] st, logic [7:0] code);
            t_result r;
            phase = PH_IDLE;
            r = current_regs();
            r.kind = KIND_DONE;
            r.status = st;
            r.link_code = code;
            pending.push_back(r);
        endfunction

        function void send_anticoll();
            phase = PH_ANTI;
            push_frame({40'd0, NVB_ANTI, select_code()}, 3'd2, 3'd0, 1'b0);
        endfunction

        // Advance the sequencer by one accepted word; return 1 when it owes a result.
        function bit note_word(logic [1:0] cmd, logic [2:0] len, logic [39:0] rx,
                               logic [7:0] lerr);
            logic [7:0] b [5];
            logic       tag;
            for (int i = 0; i < 5; i++) b[i] = rx[8*i +: 8];
            if (cmd == CMD_START) begin
                foreach (uid_store[i]) uid_store[i] = 8'h00;
                uid_count = 4'd0;
                level = 2'd0;
                tag_seen = 1'b0;
                phase = PH_ATQA;
                push_frame({48'd0, WUPA_CODE}, 3'd1, 3'd7, 1'b0);
                return 1;
            end
            if (cmd == CMD_NONE || phase == PH_IDLE) return 0;
            if (cmd == CMD_FAIL) begin
                push_done(ST_LINK, lerr);
                return 1;
            end
            case (phase)
                PH_ATQA: begin
                    if (len != 3'd2) begin
                        push_done(ST_PROTO, 8'h00);
                    end else begin
                        atqa_q = {b[1], b[0]};
                        if ((atqa_q[4:0] & ATQA_MASK) == 5'd0) begin
                            push_done(ST_PROTO, 8'h00);
                        end else begin
                            level = 2'd0;
                            send_anticoll();
                        end
                    end
                end
                PH_ANTI: begin
                    if (len != 3'd5 || (b[0] ^ b[1] ^ b[2] ^ b[3]) != b[4]) begin
                        push_done(ST_PROTO, 8'h00);
                    end else begin
                        tag = (b[0] == CASCADE_TAG);
                        tag_seen = tag;
                        for (int n = tag; n < 4; n++) begin
                            if (uid_count < UID_BYTES) begin
                                uid_store[uid_count] = b[n];
                                uid_count++;
                            end
                        end
                        phase = PH_SAK;
                        push_frame({rx, NVB_SEL, select_code()}, 3'd7, 3'd0, 1'b1);
                    end
                end
                default: begin
                    if (len != 3'd1) begin
                        push_done(ST_PROTO, 8'h00);
                    end else begin
                        sak_q = b[0];
                        if (sak_q[SAK_CASCADE_BIT] != tag_seen) begin
                            push_done(ST_PROTO, 8'h00);
                        end else if ((sak_q & SAK_CASCADE) != 8'h00) begin
                            if (level >= 2'd2) begin
                                push_done(ST_PROTO, 8'h00);
                            end else begin
                                level++;
                                send_anticoll();
                            end
                        end else begin
                            push_done(ST_OK, 8'h00);
                        end
                    end
                end
            endcase
            return 1;
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s mismatch: got %h, expected %h", name, got, want));
        endtask

        task check(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = pending.pop_front();
            field("kind", got.kind, want.kind);
            field("tx_data", got.tx_data, want.tx_data);
            field("tx_length", got.tx_length, want.tx_length);
            field("tx_last_bits", got.tx_last_bits, want.tx_last_bits);
            field("tx_crc", got.tx_crc, want.tx_crc);
            field("status", got.status, want.status);
            field("link_code", got.link_code, want.link_code);
            field("atqa", got.atqa, want.atqa);
            field("sak", got.sak, want.sak);
            field("uid_low", got.uid_low, want.uid_low);
            field("uid_high", got.uid_high, want.uid_high);
            field("uid_length", got.uid_length, want.uid_length);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    i14a_aci_in_if  in_if ();
    i14a_aci_out_if out_if ();

    iso14443a_anticollision_initiator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    uid_sequencer_scoreboard sb = new();
    bit idle_on;
    int sink_hold;
    int answered;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [39:0] with_bcc(logic [31:0] u);
        return {u[7:0] ^ u[15:8] ^ u[23:16] ^ u[31:24], u};
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [2:0] len, logic [39:0] rx,
                             logic [7:0] lerr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.command    <= cmd;
        in_if.rx_length  <= len;
        in_if.rx_data    <= rx;
        in_if.link_error <= lerr;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (sb.note_word(cmd, len, rx, lerr)) answered++;
    endtask

    task automatic send_noise();
        logic [1:0] cmd;
        cmd = ($urandom_range(0, 9) < 6) ? CMD_FRAME : 2'($urandom_range(0, 3));
        send_word(cmd, 3'($urandom_range(0, 7)), 40'({$urandom, $urandom}), 8'($urandom));
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Abandon or derail the running sequence now and then.
    task automatic maybe_spoil(int pct, output bit spoiled);
        spoiled = ($urandom_range(0, 99) < pct);
        if (spoiled && $urandom_range(0, 2) != 0) send_noise();
    endtask

    task automatic run_session(int pct);
        int          levels;
        logic [15:0] atqa;
        logic [31:0] uid4;
        logic [7:0]  sak;
        bit          spoiled;
        send_word(CMD_START, 3'($urandom), 40'({$urandom, $urandom}), 8'($urandom));
        atqa = 16'($urandom);
        atqa[$urandom_range(0, 4)] = 1'b1;
        maybe_spoil(pct, spoiled);
        if (spoiled) return;
        send_word(CMD_FRAME, 3'd2, {24'($urandom), atqa}, 8'($urandom));
        levels = $urandom_range(1, 3);
        for (int lvl = 0; lvl < levels; lvl++) begin
            uid4 = $urandom;
            if (lvl < levels - 1 || $urandom_range(0, 15) == 0) uid4[7:0] = CASCADE_TAG;
            maybe_spoil(pct, spoiled);
            if (spoiled) return;
            send_word(CMD_FRAME, 3'd5, with_bcc(uid4), 8'($urandom));
            sak = 8'($urandom);
            sak[SAK_CASCADE_BIT] = (uid4[7:0] == CASCADE_TAG);
            maybe_spoil(pct, spoiled);
            if (spoiled) return;
            send_word(CMD_FRAME, 3'd1, {32'($urandom), sak}, 8'($urandom));
        end
    endtask

    initial begin
        int burst;
        burst = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                sb.check({out_if.kind, out_if.tx_data, out_if.tx_length, out_if.tx_last_bits,
                          out_if.tx_crc, out_if.status, out_if.link_code, out_if.atqa,
                          out_if.sak, out_if.uid_low, out_if.uid_high, out_if.uid_length});
            if (sink_hold > 0) begin
                sink_hold--;
                out_if.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 15) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        bit pressed;
        pressed = 0;
        idle_on = 1'b0;
        sink_hold = 0;
        answered = 0;
        i_rst_n <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.command    <= CMD_NONE;
        in_if.rx_length  <= 3'd0;
        in_if.rx_data    <= 40'd0;
        in_if.link_error <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        send_word(CMD_FRAME, 3'd2, 40'h00_0000_0044, 8'h00);
        send_word(CMD_FAIL, 3'd0, 40'h00_0000_0000, 8'h5A);
        send_word(CMD_NONE, 3'd7, 40'hFF_FFFF_FFFF, 8'hFF);
        send_word(CMD_START, 3'd0, 40'h00_0000_0000, 8'h00);
        send_word(CMD_FRAME, 3'd2, 40'hFF_FFFF_FFE0, 8'h00);
        send_word(CMD_START, 3'd7, 40'hFF_FFFF_FFFF, 8'hFF);
        send_word(CMD_FRAME, 3'd7, 40'h00_0000_0044, 8'h00);
        send_word(CMD_START, 3'd0, 40'h00_0000_0000, 8'h00);
        send_word(CMD_START, 3'd1, 40'h12_3456_789A, 8'h00);
        send_word(CMD_FRAME, 3'd2, 40'h00_0000_0044, 8'h00);
        send_word(CMD_FRAME, 3'd5, with_bcc(32'h0302_0188), 8'h00);
        send_word(CMD_FRAME, 3'd1, 40'h00_0000_0004, 8'h00);
        send_word(CMD_FRAME, 3'd5, with_bcc(32'h0605_0488), 8'h00);
        send_word(CMD_FRAME, 3'd1, 40'hFF_FFFF_FF24, 8'h00);
        send_word(CMD_FRAME, 3'd5, with_bcc(32'hFFFE_FD88), 8'h00);
        send_word(CMD_FRAME, 3'd1, 40'h00_0000_0004, 8'h00);
        send_word(CMD_START, 3'd0, 40'h00_0000_0000, 8'h00);
        send_word(CMD_FRAME, 3'd2, 40'h00_0000_001F, 8'h00);
        send_word(CMD_FRAME, 3'd5, 40'h00_1122_3344, 8'h00);
        send_word(CMD_START, 3'd0, 40'h00_0000_0000, 8'h00);
        send_word(CMD_FRAME, 3'd2, 40'h00_0000_0001, 8'h00);
        send_word(CMD_FRAME, 3'd5, with_bcc(32'h7F80_0100), 8'h00);
        send_word(CMD_FRAME, 3'd0, 40'h00_0000_0000, 8'h00);
        send_word(CMD_START, 3'd0, 40'h00_0000_0000, 8'h00);
        send_word(CMD_FAIL, 3'd0, 40'h00_0000_0000, 8'h00);

        while (answered < 600) begin
            if ($urandom_range(0, 9) < 7) begin
                run_session(10);
            end else begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
            if (!pressed && answered >= 250) begin
                pressed = 1;
                idle_on = 1'b0;
                sink_hold = 120;
                run_session(0);
                run_session(0);
                drain_results();
                idle_on = 1'b1;
            end
        end

        drain_results();
        idle_on = 1'b0;
        while (answered < 700) begin
            if ($urandom_range(0, 9) < 8) begin
                run_session(5);
            end else begin
                send_noise();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
